// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a condition implies a consequence in the same cycle
`define ASSERT_IMP(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// a condition implies a consequence in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/mmpr_pkg.sv -----
// ----------------------------------------------------------------------------
// mmpr_pkg
// types and constants shared by the matrix power recurrence block
// ----------------------------------------------------------------------------
`default_nettype none

package mmpr_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_MUL,
    ST_OUT
  } state_t;

  localparam int BASE_BITS = 32;

endpackage

`default_nettype wire

// ----- rtl/modular_matrix_power_recurrence.sv -----
// ----------------------------------------------------------------------------
// modular_matrix_power_recurrence
// term a(n) of a(1)=c, a(n)=c*(a(n-1)+a(n-2)) mod m through 2x2 matrix powers
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_stall carries length and base; the result
//   channel out_valid/out_stall carries value and bad_length.
//   modulus is written through modulus_we/modulus_wdata while idle; the
//   user must keep to this, as the block itself does not enforce it.
//   one item at a time. base minus one is reduced modulo m by a bit-serial
//   restoring remainder and a set-up step, then the modular products run
//   on a single double-and-add unit, one cycle per multiplier bit. each
//   bit of the exponent n-1 costs 8 products (square) plus 8 more when the
//   bit is set, plus 2 for the final vector product.
//   zero length presents its result the cycle after the transfer, with
//   bad_length set.
// reset clears the sequencer and sets the modulus to 2. a stalled result is
// held in the output register; no new item is taken until it transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_matrix_power_recurrence #(
  parameter int MOD_BITS = 60,
  parameter int EXP_BITS = 32
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire [EXP_BITS-1:0]   length,
  input  wire [31:0]           base,
  input  wire                  modulus_we,
  input  wire [MOD_BITS-1:0]   modulus_wdata,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [MOD_BITS-1:0]  value,
  output logic                 bad_length
);

  `include "assert_macros.svh"

  localparam int W = MOD_BITS;
  localparam int BB = mmpr_pkg::BASE_BITS;
  localparam int BCW = $clog2(BB + 1);
  localparam int MCW = $clog2(W + 1);
  localparam int EW = EXP_BITS;

  mmpr_pkg::state_t state, state_next;

  logic [W-1:0]  modulus;
  logic [W-1:0]  m;
  logic [W-1:0]  c;
  logic [W-1:0]  one;
  logic [W-1:0]  p [4];
  logic [W-1:0]  s [4];
  logic [W-1:0]  t [4];
  logic [EW-1:0] exponent_left;
  logic          mult_phase;     // 1: multiply p*s, 0: square s
  logic [3:0]    prod_idx;       // which of the 8 products (2 per entry)
  logic          final_phase;
  // serial remainder
  logic [BB-1:0] rem_src;
  logic [BCW-1:0] bcnt;
  // serial multiplier
  logic [W-1:0]  acc;
  logic [W-1:0]  ma;
  logic [W-1:0]  mb;
  logic [MCW-1:0] mcnt;
  logic [W-1:0]  half;

  assign m = (modulus == '0) ? W'(1) : modulus;

  // modular add of two residues
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a,
                                           input logic [W-1:0] b,
                                           input logic [W-1:0] mm);
    logic [W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, mm}) return W'(sum - {1'b0, mm});
    return sum[W-1:0];
  endfunction

  // operand selection for product number prod_idx
  always_comb begin
    logic [1:0] e;
    logic       k;
    logic [W-1:0] x0, x1, y0, y1;
    e = prod_idx[2:1];
    k = prod_idx[0];
    x0 = mult_phase ? p[{e[1], 1'b0}] : s[{e[1], 1'b0}];
    x1 = mult_phase ? p[{e[1], 1'b1}] : s[{e[1], 1'b1}];
    y0 = s[{1'b0, e[0]}];
    y1 = s[{1'b1, e[0]}];
    if (final_phase) begin
      ma = k ? p[1] : p[0];
      mb = k ? one : c;
    end else begin
      ma = k ? x1 : x0;
      mb = k ? y1 : y0;
    end
  end

  // double-and-add step, msb of mb first
  logic [W-1:0] dbl, step_acc;
  always_comb begin
    dbl = add_mod(acc, acc, m);
    step_acc = mb[mcnt - MCW'(1)] ? add_mod(dbl, ma, m) : dbl;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mmpr_pkg::ST_IDLE: if (in_valid) state_next = (length == '0) ?
                                       mmpr_pkg::ST_OUT : mmpr_pkg::ST_RED;
      mmpr_pkg::ST_RED:  if (bcnt == '0) state_next = mmpr_pkg::ST_MUL;
      mmpr_pkg::ST_MUL:  if (mcnt == MCW'(1) && final_phase && prod_idx[0])
                           state_next = mmpr_pkg::ST_OUT;
      mmpr_pkg::ST_OUT:  if (!out_stall) state_next = mmpr_pkg::ST_IDLE;
      default:           state_next = mmpr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state != mmpr_pkg::ST_IDLE);
    out_valid = (state == mmpr_pkg::ST_OUT);
  end

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) modulus <= W'(2);
    else if (modulus_we) modulus <= modulus_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mmpr_pkg::ST_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      mmpr_pkg::ST_IDLE: begin
        if (in_valid) begin
          rem_src <= base - BB'(1);
          bcnt <= BCW'(BB);
          c <= '0;
          exponent_left <= length - EW'(1);
          bad_length <= (length == '0);
          value <= '0;
          one <= (m == W'(1)) ? '0 : W'(1);
          mult_phase <= 1'b1;
          final_phase <= 1'b0;
          prod_idx <= '0;
          mcnt <= MCW'(W);
          acc <= '0;
        end
      end
      mmpr_pkg::ST_RED: begin
        // restoring remainder, one bit a cycle
        if (bcnt != '0) begin
          logic [W:0] r2;
          r2 = {c, rem_src[BB-1]};
          c <= (r2 >= {1'b0, m}) ? W'(r2 - {1'b0, m}) : r2[W-1:0];
          rem_src <= rem_src << 1;
          bcnt <= bcnt - BCW'(1);
        end else begin
          p[0] <= one; p[1] <= '0; p[2] <= '0; p[3] <= one;
          s[0] <= c; s[1] <= c; s[2] <= one; s[3] <= '0;
          mult_phase <= exponent_left[0];
          final_phase <= (exponent_left == '0);
        end
      end
      mmpr_pkg::ST_MUL: begin
        if (mcnt != MCW'(1)) begin
          acc <= step_acc;
          mcnt <= mcnt - MCW'(1);
        end else begin
          acc <= '0;
          mcnt <= MCW'(W);
          if (!prod_idx[0]) begin
            half <= step_acc;
            prod_idx <= prod_idx + 4'd1;
          end else if (final_phase) begin
            value <= add_mod(half, step_acc, m);
          end else begin
            t[prod_idx[2:1]] <= add_mod(half, step_acc, m);
            if (prod_idx != 4'd7) begin
              prod_idx <= prod_idx + 4'd1;
            end else begin
              prod_idx <= '0;
              if (mult_phase) begin
                p[0] <= t[0]; p[1] <= t[1]; p[2] <= t[2];
                p[3] <= add_mod(half, step_acc, m);
                mult_phase <= 1'b0;
              end else begin
                s[0] <= t[0]; s[1] <= t[1]; s[2] <= t[2];
                s[3] <= add_mod(half, step_acc, m);
                exponent_left <= exponent_left >> 1;
                mult_phase <= exponent_left[1];
                final_phase <= ((exponent_left >> 1) == '0);
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // assertions
  `ASSERT_IMP(a_out_idle, clk, rst, out_valid, in_stall)
  `ASSERT_NEXT(a_zero_len, clk, rst,
    (state == mmpr_pkg::ST_IDLE && in_valid && length == '0),
    (out_valid && bad_length && value == '0))
  `ASSERT_IMP(a_val_range, clk, rst, (out_valid && !bad_length), (value < m))

endmodule

`default_nettype wire

// ----- tb/modular_matrix_power_recurrence_tb.sv -----
// ----------------------------------------------------------------------------
// modular_matrix_power_recurrence_tb
// self-checking bench: directed and random terms under several moduli, a
// predictor of the matrix power recurrence, and random idling on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module modular_matrix_power_recurrence_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MOD_BITS = 60;
  localparam int EXP_BITS = 32;
  localparam longint unsigned MOD_MAX = (64'd1 << MOD_BITS) - 1;
  localparam int CYCLE_LIMIT = 16000000;

  typedef struct {
    logic [MOD_BITS-1:0] value;
    logic                bad_length;
  } term_t;

  // expected terms and the predictor of the recurrence
  class term_scoreboard;
    term_t           pending[$];
    longint unsigned modulus = 2;
    int              errors = 0;

    function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                               longint unsigned m);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return longint'(p % {64'd0, m});
    endfunction

    function automatic longint unsigned addmod(longint unsigned a, longint unsigned b,
                                               longint unsigned m);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return longint'(s % {1'b0, m});
    endfunction

    // r = x * y for row-major 2x2 matrices
    function automatic void matmul(ref longint unsigned r[4], input longint unsigned x[4],
                                   input longint unsigned y[4], input longint unsigned m);
      longint unsigned t[4];
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          t[i*2+j] = addmod(mulmod(x[i*2], y[j], m), mulmod(x[i*2+1], y[2+j], m), m);
      r = t;
    endfunction

    function automatic void note_input(logic [EXP_BITS-1:0] n, logic [31:0] k);
      term_t           t;
      longint unsigned m, c, one;
      longint unsigned pw[4], sq[4];
      logic [31:0]     km1;
      logic [EXP_BITS-1:0] e;
      m = (modulus == 0) ? 1 : modulus;
      if (n == 0) begin
        t.value = '0;
        t.bad_length = 1'b1;
      end else begin
        km1 = k - 32'd1;
        c = {32'd0, km1} % m;
        one = 1 % m;
        pw = '{one, 0, 0, one};
        sq = '{c, c, one, 0};
        e = n - 1;
        while (e != 0) begin
          if (e[0]) matmul(pw, pw, sq, m);
          matmul(sq, sq, sq, m);
          e = e >> 1;
        end
        t.value = MOD_BITS'(addmod(mulmod(pw[0], c, m), mulmod(pw[1], one, m), m));
        t.bad_length = 1'b0;
      end
      pending.push_back(t);
    endfunction

    function automatic void check_result(logic [MOD_BITS-1:0] v, logic bad);
      term_t t;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value %0h bad_length %0b", $time, v, bad);
        errors++;
        return;
      end
      t = pending.pop_front();
      if (v !== t.value) begin
        $display("%0t: value expected %0h actual %0h", $time, t.value, v);
        errors++;
      end
      if (bad !== t.bad_length) begin
        $display("%0t: bad_length expected %0b actual %0b", $time, t.bad_length, bad);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [EXP_BITS-1:0] length;
  logic [31:0]         base;
  logic                modulus_we;
  logic [MOD_BITS-1:0] modulus_wdata;
  logic                out_valid;
  logic                out_stall;
  logic [MOD_BITS-1:0] value;
  logic                bad_length;

  term_scoreboard sb;
  int             send_idle_pct;
  int             recv_idle_pct;
  int             cycles;

  modular_matrix_power_recurrence #(
    .MOD_BITS(MOD_BITS),
    .EXP_BITS(EXP_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .length       (length),
    .base         (base),
    .modulus_we   (modulus_we),
    .modulus_wdata(modulus_wdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .bad_length   (bad_length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver stalls
  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < recv_idle_pct);
  end

  // result transfer check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(value, bad_length);
  end

  // run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("modular_matrix_power_recurrence: mismatch");
      $finish;
    end
  end

  // one input transfer, called at a falling edge
  task automatic send_term(logic [EXP_BITS-1:0] n, logic [31:0] k);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    length = n;
    base = k;
    do @(posedge clk); while (in_stall);
    sb.note_input(n, k);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // modulus write while the block is idle
  task automatic write_modulus(longint unsigned m);
    wait_drained();
    modulus_we = 1'b1;
    modulus_wdata = MOD_BITS'(m);
    @(negedge clk);
    modulus_we = 1'b0;
    sb.modulus = m;
  endtask

  function automatic longint unsigned random_modulus();
    longint unsigned m;
    m = {$urandom, $urandom} & MOD_MAX;
    if ($urandom_range(0, 1)) m = m >> $urandom_range(0, 56);
    return (m < 2) ? 2 : m;
  endfunction

  // mostly short terms, some zero, a few with full-width indexes
  task automatic random_terms(int count, bit drain_once);
    logic [EXP_BITS-1:0] n;
    logic [31:0]         k;
    int                  r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) n = '0;
      else if (r < 8) n = $urandom;
      else n = $urandom_range(1, 20);
      r = $urandom_range(0, 99);
      if (r < 5) k = 32'd0;
      else if (r < 10) k = 32'd1;
      else if (r < 15) k = 32'hFFFF_FFFF;
      else k = $urandom;
      if (drain_once && i == count / 2) wait_drained();
      send_term(n, k);
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    length = '0;
    base = '0;
    modulus_we = 1'b0;
    modulus_wdata = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset modulus of two
    send_term(32'd0, 32'd5);
    send_term(32'd1, 32'd2);
    send_term(32'd2, 32'd0);
    send_term(32'd3, 32'd1);
    send_term(32'd5, 32'hFFFF_FFFF);

    // directed: widest modulus, extreme lengths and bases
    write_modulus(MOD_MAX);
    send_term(32'd1, 32'd0);
    send_term(32'd1, 32'hFFFF_FFFF);
    send_term(32'd2, 32'd1);
    send_term(32'd7, 32'd2);
    send_term(32'd0, 32'd0);
    send_term(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_term(32'h8000_0000, 32'h5555_AAAA);
    send_term(32'd33, 32'hAAAA_5555);

    // directed: small modulus, bases including one above a multiple of it
    write_modulus(64'd3);
    send_term(32'd4, 32'd7);
    send_term(32'd6, 32'd3);
    send_term(32'd9, 32'd2);

    // sender idles lightly, receiver heavily
    write_modulus(random_modulus());
    send_idle_pct = 22;
    recv_idle_pct = 80;
    random_terms(35, 1'b1);

    // the other way round
    write_modulus(random_modulus());
    send_idle_pct = 80;
    recv_idle_pct = 22;
    random_terms(35, 1'b0);

    // no idling, extreme moduli
    write_modulus(64'd2);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_terms(10, 1'b0);
    write_modulus(MOD_MAX);
    random_terms(20, 1'b0);

    wait_drained();
    repeat (40) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("modular_matrix_power_recurrence: match");
    end else begin
      $display("modular_matrix_power_recurrence: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
